>>> rtl/core/spi_sram_access_master_macros.svh
// Assertion macros used by the file that checks the block.
`ifndef SPI_SRAM_ACCESS_MASTER_MACROS_SVH
`define SPI_SRAM_ACCESS_MASTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSAM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSAM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/ssam_pkg.sv
package ssam_pkg;

   localparam int unsigned ADDR_FIELD_W = 16;

   localparam logic [1:0] KIND_READ   = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   localparam logic [7:0] OP_READ   = 8'h03;
   localparam logic [7:0] OP_WRITE  = 8'h02;
   localparam logic [7:0] OP_STATUS = 8'h01;

   localparam logic [7:0] HALF_PERIOD_RESET = 8'd1;
   localparam logic [7:0] STATUS_MODE_RESET = 8'h41;

   localparam logic CSR_HALF_PERIOD = 1'b0;
   localparam logic CSR_STATUS_MODE = 1'b1;

   typedef struct packed {
      logic       cs_n;
      logic       sck;
      logic       si;
      logic [7:0] read_data;
      logic       read_valid;
      logic       busy_res;
   } rsp_type;

endpackage

>>> rtl/core/ssam_engine.sv
module ssam_engine #(
   parameter int unsigned ADDRESS_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic                                start_req,
   input  logic [1:0]                          kind,
   input  logic [ssam_pkg::ADDR_FIELD_W-1:0]   address,
   input  logic [7:0]                          write_data,
   input  logic                                so_in,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [7:0]                          csr_wdata,
   output ssam_pkg::rsp_type                   result
);
   import ssam_pkg::*;

   localparam int unsigned FRAME_W = ADDRESS_BITS + 16;
   localparam int unsigned IDX_W = $clog2(FRAME_W);
   localparam logic [5:0] BITS_ACCESS = 6'(FRAME_W);
   localparam logic [5:0] BITS_STATUS = 6'd16;
   localparam logic [5:0] BITS_DATA = 6'd8;

   logic [7:0]         half_period_ff, half_period_in;
   logic [7:0]         status_mode_ff, status_mode_in;
   logic               active_ff, active_in;
   logic               phase_ff, phase_in;
   logic [5:0]         bits_left_ff, bits_left_in;
   logic [1:0]         kind_ff, kind_in;
   logic [7:0]         divider_ff, divider_in;
   logic [7:0]         rx_ff, rx_in;
   logic [7:0]         last_read_ff, last_read_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;

   logic [ADDRESS_BITS-1:0] addr_masked;
   logic [7:0]              half_eff;
   logic [7:0]              divider_inc;
   logic [5:0]              bits_dec;
   logic [5:0]              si_pos;
   logic                    read_valid;
   logic                    si;

   assign addr_masked = ADDRESS_BITS'(address);
   assign half_eff = (half_period_ff == 8'd0) ? 8'd1 : half_period_ff;
   assign divider_inc = divider_ff + 8'd1;
   assign bits_dec = (bits_left_ff != 6'd0) ? bits_left_ff - 6'd1 : bits_left_ff;

   always_comb begin
      half_period_in = half_period_ff;
      status_mode_in = status_mode_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HALF_PERIOD: half_period_in = csr_wdata;
            CSR_STATUS_MODE: status_mode_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      active_in = active_ff;
      phase_in = phase_ff;
      bits_left_in = bits_left_ff;
      kind_in = kind_ff;
      divider_in = divider_ff;
      rx_in = rx_ff;
      last_read_in = last_read_ff;
      frame_in = frame_ff;
      read_valid = 1'b0;
      if (!active_ff) begin
         if (start_req && (kind != KIND_NONE)) begin
            active_in = 1'b1;
            phase_in = 1'b0;
            kind_in = kind;
            divider_in = 8'd0;
            rx_in = 8'd0;
            case (kind)
               KIND_READ: begin
                  frame_in = {OP_READ, addr_masked, 8'h00};
                  bits_left_in = BITS_ACCESS;
               end
               KIND_WRITE: begin
                  frame_in = {OP_WRITE, addr_masked, write_data};
                  bits_left_in = BITS_ACCESS;
               end
               default: begin
                  frame_in = FRAME_W'({OP_STATUS, status_mode_ff});
                  bits_left_in = BITS_STATUS;
               end
            endcase
         end
      end else if (divider_inc >= half_eff) begin
         divider_in = 8'd0;
         if (!phase_ff) begin
            phase_in = 1'b1;
            if ((kind_ff == KIND_READ) && (bits_left_ff <= BITS_DATA)) begin
               rx_in = {rx_ff[6:0], so_in};
            end
         end else begin
            phase_in = 1'b0;
            bits_left_in = bits_dec;
            if (bits_dec == 6'd0) begin
               active_in = 1'b0;
               if (kind_ff == KIND_READ) begin
                  last_read_in = rx_ff;
                  read_valid = 1'b1;
               end
            end
         end
      end else begin
         divider_in = divider_inc;
      end
   end

   assign si_pos = bits_left_in - 6'd1;
   assign si = active_in && (bits_left_in != 6'd0) && frame_in[si_pos[IDX_W-1:0]];

   always_comb begin
      result.cs_n = !active_in;
      result.sck = active_in && phase_in;
      result.si = si;
      result.read_data = last_read_in;
      result.read_valid = read_valid;
      result.busy_res = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         status_mode_ff <= STATUS_MODE_RESET;
      end else begin
         half_period_ff <= half_period_in;
         status_mode_ff <= status_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff <= 1'b0;
         bits_left_ff <= 6'd0;
         kind_ff <= KIND_READ;
         divider_ff <= 8'd0;
         rx_ff <= 8'd0;
         last_read_ff <= 8'd0;
      end else if (step) begin
         active_ff <= active_in;
         phase_ff <= phase_in;
         bits_left_ff <= bits_left_in;
         kind_ff <= kind_in;
         divider_ff <= divider_in;
         rx_ff <= rx_in;
         last_read_ff <= last_read_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         frame_ff <= frame_in;
      end
   end

endmodule

>>> rtl/core/ssam_rsp_buf.sv
module ssam_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ssam_pkg::rsp_type push_data,
   input  logic              rsp_stall,
   output logic              full,
   output logic              rsp_valid,
   output ssam_pkg::rsp_type rsp_data
);
   import ssam_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in = out_ff;
      skid_in = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   assign full = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

endmodule

>>> rtl/core/spi_sram_access_master.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  start_req, kind, address, write_data, so_in
// rsp       out        rsp_valid / rsp_stall  cs_n, sck, si, read_data, read_valid, busy_res
// csr       in         csr_we                 csr_index, csr_wdata
//
// Each request is one tick of the serial interface.
// A request can be accepted every cycle while req_stall is low; its response is registered in the output buffer.
// A two-entry output buffer holds responses, so req_stall rises only when both entries are full.
// Synchronous reset returns the engine to idle, empties the output buffer and restores the register defaults.
module spi_sram_access_master #(
   parameter int unsigned ADDRESS_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_start_req,
   input  logic [1:0]                        req_kind,
   input  logic [ssam_pkg::ADDR_FIELD_W-1:0] req_address,
   input  logic [7:0]                        req_write_data,
   input  logic                              req_so_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_cs_n,
   output logic                              rsp_sck,
   output logic                              rsp_si,
   output logic [7:0]                        rsp_read_data,
   output logic                              rsp_read_valid,
   output logic                              rsp_busy_res,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [7:0]                        csr_wdata
);
   import ssam_pkg::*;

   `include "spi_sram_access_master_macros.svh"

   logic    step;
   logic    buf_full;
   rsp_type step_result;
   rsp_type rsp_data;

   assign req_stall = buf_full;
   assign step = req_valid && !buf_full;

   ssam_engine #(
      .ADDRESS_BITS(ADDRESS_BITS)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .step(step),
      .start_req(req_start_req),
      .kind(req_kind),
      .address(req_address),
      .write_data(req_write_data),
      .so_in(req_so_in),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .result(step_result)
   );

   ssam_rsp_buf u_rsp_buf (
      .clock(clock),
      .reset(reset),
      .push(step),
      .push_data(step_result),
      .rsp_stall(rsp_stall),
      .full(buf_full),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   assign rsp_cs_n = rsp_data.cs_n;
   assign rsp_sck = rsp_data.sck;
   assign rsp_si = rsp_data.si;
   assign rsp_read_data = rsp_data.read_data;
   assign rsp_read_valid = rsp_data.read_valid;
   assign rsp_busy_res = rsp_data.busy_res;

   `SSAM_ASSERT_NOW(a_valid_ends_access, clock, reset, step && step_result.read_valid, step_result.cs_n && !step_result.busy_res, "read byte reported while the access is still open")
   `SSAM_ASSERT_NOW(a_sck_needs_cs, clock, reset, step && step_result.sck, !step_result.cs_n, "serial clock high with chip select released")
   `SSAM_ASSERT_NOW(a_skid_behind_out, clock, reset, buf_full, rsp_valid, "skid entry held while the output entry is empty")
   `SSAM_ASSERT_NEXT(a_skid_drains, clock, reset, buf_full && !rsp_stall, rsp_valid && !buf_full, "skid entry not moved forward after a response was taken")

endmodule
